// ===== hdl/falru_pkg.sv =====
package falru_pkg;

  // Field widths of the channel payloads
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned LINE_IDX_W  = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_FILL   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } state_t;

  // Control broadcast from the sequencer to every line cell
  typedef struct packed {
    logic eval;
    logic commit;
    logic touch;
    op_t  op;
  } cell_ctl_t;

endpackage

// ===== hdl/falru_chan_if.sv =====
interface falru_in_if;
  logic                                valid;
  logic                                ready;
  logic [falru_pkg::OPCODE_W-1:0]      opcode;
  logic [falru_pkg::TAG_W-1:0]         tag;
  logic [falru_pkg::DATA_W-1:0]        line_data;

  modport source (output valid, output opcode, output tag, output line_data, input ready);
  modport sink   (input valid, input opcode, input tag, input line_data, output ready);
endinterface

interface falru_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [falru_pkg::LINE_IDX_W-1:0]    line_index;
  logic                                evict_valid;
  logic [falru_pkg::TAG_W-1:0]         evicted_tag;
  logic [falru_pkg::DATA_W-1:0]        evicted_data;

  modport source (output valid, output hit, output line_index, output evict_valid,
                  output evicted_tag, output evicted_data, input ready);
  modport sink   (input valid, input hit, input line_index, input evict_valid,
                  input evicted_tag, input evicted_data, output ready);
endinterface

interface falru_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/falru_cell.sv =====
module falru_cell #(
  parameter int unsigned ENTRIES   = 8,
  parameter int unsigned TAG_BITS  = 16,
  parameter int unsigned DATA_BITS = 32,
  parameter int unsigned INDEX     = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  falru_pkg::cell_ctl_t               ctl,
  input  logic [TAG_BITS-1:0]                req_tag,
  input  logic [DATA_BITS-1:0]               req_data,
  input  logic [$clog2(ENTRIES)-1:0]         old_rank,
  // chain from the lower-index neighbour
  input  logic                               found_in,
  input  logic [$clog2(ENTRIES)-1:0]         rank_in,
  input  logic [$clog2(ENTRIES)-1:0]         idx_in,
  input  logic [TAG_BITS-1:0]                tag_in,
  input  logic [DATA_BITS-1:0]               data_in,
  // chain to the higher-index neighbour
  output logic                               found_out,
  output logic [$clog2(ENTRIES)-1:0]         rank_out,
  output logic [$clog2(ENTRIES)-1:0]         idx_out,
  output logic [TAG_BITS-1:0]                tag_out,
  output logic [DATA_BITS-1:0]               data_out
);

  localparam int unsigned RANK_BITS = $clog2(ENTRIES);
  localparam logic [RANK_BITS-1:0] MY_IDX   = RANK_BITS'(INDEX);
  localparam logic [RANK_BITS-1:0] MRU_RANK = RANK_BITS'(ENTRIES - 1);

  logic [TAG_BITS-1:0]  tag_r,  tag_nxt;
  logic [DATA_BITS-1:0] data_r, data_nxt;
  logic [RANK_BITS-1:0] rank_r, rank_nxt;
  logic                 sel_r,  sel_nxt;
  logic                 match;
  logic                 pick;

  // Claim this line if it is the first match or the oldest line
  always_comb begin
    match = (tag_r == req_tag);
    case (ctl.op)
      falru_pkg::OP_LOOKUP: pick = match && !found_in;
      falru_pkg::OP_UPDATE: pick = match && !found_in;
      falru_pkg::OP_FILL:   pick = (rank_r == '0);
      default:              pick = 1'b0;
    endcase
  end

  // Pass the claim and the claimed line's contents up the chain
  assign found_out = found_in | pick;
  assign rank_out  = rank_in | (pick ? rank_r : '0);
  assign idx_out   = idx_in  | (pick ? MY_IDX : '0);
  assign tag_out   = tag_in  | (pick ? tag_r  : '0);
  assign data_out  = data_in | (pick ? data_r : '0);

  // Write the line and age its rank on commit
  always_comb begin
    tag_nxt  = tag_r;
    data_nxt = data_r;
    rank_nxt = rank_r;
    sel_nxt  = sel_r;
    if (ctl.eval) begin
      sel_nxt = pick;
    end
    if (ctl.commit) begin
      if (sel_r) begin
        case (ctl.op)
          falru_pkg::OP_FILL: begin
            tag_nxt  = req_tag;
            data_nxt = req_data;
            rank_nxt = MRU_RANK;
          end
          falru_pkg::OP_UPDATE: data_nxt = req_data;
          falru_pkg::OP_LOOKUP: rank_nxt = MRU_RANK;
          default:              rank_nxt = rank_r;
        endcase
      end else if (ctl.touch && (rank_r > old_rank)) begin
        rank_nxt = rank_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= '0;
      data_r <= '0;
      rank_r <= MY_IDX;
      sel_r  <= 1'b0;
    end else begin
      tag_r  <= tag_nxt;
      data_r <= data_nxt;
      rank_r <= rank_nxt;
      sel_r  <= sel_nxt;
    end
  end

endmodule

// ===== hdl/fully_assoc_lru_tag_store_unit.sv =====
// Fully associative tag store of ENTRIES lines with least-recently-used replacement.
// Input channel in_ch carries opcode (lookup, fill, update), tag and line_data; one
// beat is taken when valid and ready are both high. Result channel out_ch returns one
// beat per input beat, in order: hit, line_index, evict_valid, evicted_tag and
// evicted_data. Configuration channel cfg_ch writes forward_enable; it is always ready.
// Each item passes through accept, evaluate (every line compares its tag and the
// first claim ripples along the row of line cells) and commit (lines and ranks written,
// result loaded into the output register). The next item is accepted in the cycle
// after commit, so the block takes no new item before it has finished the last one.
// The output register holds a result while the receiver stalls; the next item is still
// taken and evaluated, and waits at commit until the held result is taken.
// Synchronous active-low reset clears all tags and data to zero, sets each line's rank
// to its index (line 0 is least recently used) and clears forward_enable.
module fully_assoc_lru_tag_store_unit #(
  parameter int unsigned ENTRIES   = 8,
  parameter int unsigned TAG_BITS  = 16,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  falru_in_if.sink     in_ch,
  falru_out_if.source  out_ch,
  falru_cfg_if.sink    cfg_ch
);

  localparam int unsigned RANK_BITS = $clog2(ENTRIES);
  localparam int unsigned TW = falru_pkg::TAG_W;
  localparam int unsigned DW = falru_pkg::DATA_W;
  localparam int unsigned LW = falru_pkg::LINE_IDX_W;

  falru_pkg::state_t    state_r, state_nxt;
  falru_pkg::op_t       req_op_r;
  logic [TAG_BITS-1:0]  req_tag_r;
  logic [DATA_BITS-1:0] req_data_r;
  logic                 fwd_en_r;

  logic                 found_r;
  logic [RANK_BITS-1:0] g_rank_r;
  logic [RANK_BITS-1:0] g_idx_r;
  logic [TAG_BITS-1:0]  g_tag_r;
  logic [DATA_BITS-1:0] g_data_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r;
  logic [LW-1:0]        out_idx_r;
  logic                 out_ev_r;
  logic [TW-1:0]        out_tag_r;
  logic [DW-1:0]        out_data_r;

  logic                 in_ready;
  logic                 out_free;
  logic                 do_eval;
  logic                 do_commit;
  falru_pkg::cell_ctl_t ctl;

  logic [TAG_BITS+TW-1:0]  tag_in_ext;
  logic [DATA_BITS+DW-1:0] data_in_ext;
  logic [TAG_BITS+TW-1:0]  tag_out_ext;
  logic [DATA_BITS+DW-1:0] data_out_ext;
  logic [RANK_BITS+LW-1:0] idx_out_ext;

  logic                 found_c [ENTRIES+1];
  logic [RANK_BITS-1:0] rank_c  [ENTRIES+1];
  logic [RANK_BITS-1:0] idx_c   [ENTRIES+1];
  logic [TAG_BITS-1:0]  tag_c   [ENTRIES+1];
  logic [DATA_BITS-1:0] data_c  [ENTRIES+1];

  logic                 res_hit;
  logic                 res_is_fill;

  // Fit the channel fields to the stored widths
  assign tag_in_ext  = {{TAG_BITS{1'b0}}, in_ch.tag};
  assign data_in_ext = {{DATA_BITS{1'b0}}, in_ch.line_data};

  // Configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      fwd_en_r <= cfg_ch.data;
    end
  end

  // Sequencer: next state
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      falru_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = falru_pkg::ST_EVAL;
      falru_pkg::ST_EVAL:   state_nxt = falru_pkg::ST_COMMIT;
      falru_pkg::ST_COMMIT: if (out_free) state_nxt = falru_pkg::ST_IDLE;
      default:              state_nxt = falru_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready  = 1'b0;
    do_eval   = 1'b0;
    do_commit = 1'b0;
    case (state_r)
      falru_pkg::ST_IDLE:   in_ready  = 1'b1;
      falru_pkg::ST_EVAL:   do_eval   = 1'b1;
      falru_pkg::ST_COMMIT: do_commit = out_free;
      default:              in_ready  = 1'b0;
    endcase
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= falru_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      req_op_r   <= falru_pkg::op_t'(in_ch.opcode);
      req_tag_r  <= tag_in_ext[TAG_BITS-1:0];
      req_data_r <= data_in_ext[DATA_BITS-1:0];
    end
  end

  assign ctl.eval   = do_eval;
  assign ctl.commit = do_commit;
  assign ctl.op     = req_op_r;
  assign ctl.touch  = (req_op_r == falru_pkg::OP_FILL) ||
                      ((req_op_r == falru_pkg::OP_LOOKUP) && found_r);

  // Row of line cells, lowest index first
  assign found_c[0] = 1'b0;
  assign rank_c[0]  = '0;
  assign idx_c[0]   = '0;
  assign tag_c[0]   = '0;
  assign data_c[0]  = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_line
    falru_cell #(
      .ENTRIES  (ENTRIES),
      .TAG_BITS (TAG_BITS),
      .DATA_BITS(DATA_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .req_tag  (req_tag_r),
      .req_data (req_data_r),
      .old_rank (g_rank_r),
      .found_in (found_c[i]),
      .rank_in  (rank_c[i]),
      .idx_in   (idx_c[i]),
      .tag_in   (tag_c[i]),
      .data_in  (data_c[i]),
      .found_out(found_c[i+1]),
      .rank_out (rank_c[i+1]),
      .idx_out  (idx_c[i+1]),
      .tag_out  (tag_c[i+1]),
      .data_out (data_c[i+1])
    );
  end

  // Capture what the chain gathered
  always_ff @(posedge clk) begin
    if (do_eval) begin
      found_r  <= found_c[ENTRIES];
      g_rank_r <= rank_c[ENTRIES];
      g_idx_r  <= idx_c[ENTRIES];
      g_tag_r  <= tag_c[ENTRIES];
      g_data_r <= data_c[ENTRIES];
    end
  end

  // Form the result
  assign res_is_fill  = (req_op_r == falru_pkg::OP_FILL);
  assign res_hit      = found_r && ((req_op_r == falru_pkg::OP_LOOKUP) ||
                                    (req_op_r == falru_pkg::OP_UPDATE));
  assign idx_out_ext  = {{LW{1'b0}}, g_idx_r};
  assign tag_out_ext  = {{TW{1'b0}}, (res_is_fill ? g_tag_r : {TAG_BITS{1'b0}})};
  assign data_out_ext = {{DW{1'b0}}, (res_is_fill ? g_data_r : {DATA_BITS{1'b0}})};

  // Output register: load on commit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (do_commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_commit) begin
      out_hit_r  <= res_hit;
      out_idx_r  <= idx_out_ext[LW-1:0];
      out_ev_r   <= res_is_fill && fwd_en_r;
      out_tag_r  <= tag_out_ext[TW-1:0];
      out_data_r <= data_out_ext[DW-1:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.line_index   = out_idx_r;
  assign out_ch.evict_valid  = out_ev_r;
  assign out_ch.evicted_tag  = out_tag_r;
  assign out_ch.evicted_data = out_data_r;

endmodule

// ===== hdl/falru_checker.sv =====
module falru_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_hit,
  input logic                                out_evict_valid,
  input logic [falru_pkg::TAG_W-1:0]         out_evicted_tag,
  input logic [falru_pkg::DATA_W-1:0]        out_evicted_data
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The block works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A hit never carries eviction fields
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evict_valid && (out_evicted_tag == '0) &&
                             (out_evicted_data == '0))
    else $error("eviction fields set on a hit");

  // An item accepted while no result is held gives a result once evaluate and commit are done
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |-> ##3 out_valid)
    else $error("result missing three cycles after accept");

endmodule

bind fully_assoc_lru_tag_store_unit falru_checker u_falru_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_hit         (out_ch.hit),
  .out_evict_valid (out_ch.evict_valid),
  .out_evicted_tag (out_ch.evicted_tag),
  .out_evicted_data(out_ch.evicted_data)
);
